// ----- rtl/core/cpl_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the closest points between lines block.
// Used by the divider and the top level; depends on nothing.
package cpl_pkg;

    localparam int WIDE_BITS = 62;
    localparam int LIMIT_BITS = 31;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 31'd7;

endpackage

// ----- rtl/core/cpl_mul.sv -----
`timescale 1ns / 1ps
// Three-stage signed multiplier built from four half-width partial products.
// Stand-alone; the caller tracks valid bits and drives the stage enable.
module cpl_mul #(
    parameter int W = 62
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   x,
    input  logic signed [W-1:0]   y,
    output logic signed [2*W-1:0] p
);

    localparam int H = (W + 1) / 2;
    localparam int PW = 2 * W;

    logic           neg_next, neg1_reg, neg2_reg;
    logic [W-1:0]   xm_next, ym_next, xm_reg, ym_reg;
    logic [2*H-1:0] pp00_next, pp01_next, pp10_next, pp11_next;
    logic [2*H-1:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [PW-1:0]  mag;
    logic [PW-1:0]  p_next, p_reg;

    always_comb
    begin
        neg_next = x[W-1] ^ y[W-1];
        xm_next = x[W-1] ? W'(-x) : W'(x);
        ym_next = y[W-1] ? W'(-y) : W'(y);
    end

    always_comb
    begin
        pp00_next = (2*H)'(xm_reg[H-1:0]) * (2*H)'(ym_reg[H-1:0]);
        pp01_next = (2*H)'(xm_reg[H-1:0]) * (2*H)'(ym_reg[W-1:H]);
        pp10_next = (2*H)'(xm_reg[W-1:H]) * (2*H)'(ym_reg[H-1:0]);
        pp11_next = (2*H)'(xm_reg[W-1:H]) * (2*H)'(ym_reg[W-1:H]);
    end

    always_comb
    begin
        mag = PW'(pp00_reg) + ((PW'(pp01_reg) + PW'(pp10_reg)) << H)
            + (PW'(pp11_reg) << (2 * H));
        p_next = neg2_reg ? (~mag + PW'(1)) : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= neg_next;
            xm_reg   <= xm_next;
            ym_reg   <= ym_next;
            neg2_reg <= neg1_reg;
            pp00_reg <= pp00_next;
            pp01_reg <= pp01_next;
            pp10_reg <= pp10_next;
            pp11_reg <= pp11_next;
            p_reg    <= p_next;
        end
    end

    assign p = $signed(p_reg);

endmodule

// ----- rtl/core/cpl_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, truncating toward
// zero with saturation and a zero result for a zero divisor. Uses cpl_pkg.
module cpl_div #(
    parameter int NUM_W = 125
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [NUM_W-1:0]             num,
    input  logic signed [cpl_pkg::WIDE_BITS-1:0] den,
    output logic signed [cpl_pkg::WIDE_BITS-1:0] quo
);

    localparam int DW = cpl_pkg::WIDE_BITS;
    localparam int QB = DW - 1;
    localparam int HW = NUM_W - QB;
    localparam logic [DW-1:0] Q_MAX = {1'b0, {QB{1'b1}}};
    localparam logic [DW-1:0] Q_MIN = {1'b1, {QB{1'b0}}};

    logic             neg1_next, zero1_next;
    logic [NUM_W-1:0] nm_next;
    logic [DW-1:0]    dm_next;
    logic             neg1_reg, zero1_reg;
    logic [NUM_W-1:0] nm_reg;
    logic [DW-1:0]    dm1_reg;

    logic [HW-1:0]    hi_part;
    logic             ovf_next;

    logic [DW-1:0] rem_reg [0:QB];
    logic [QB-1:0] lo_reg  [0:QB];
    logic [QB-1:0] qt_reg  [0:QB];
    logic [DW-1:0] dm_reg  [0:QB];
    logic          neg_reg [0:QB];
    logic          zero_reg[0:QB];
    logic          ovf_reg [0:QB];

    logic [DW-1:0] q_next, q_reg;

    always_comb
    begin
        neg1_next = num[NUM_W-1] ^ den[DW-1];
        zero1_next = (den == '0);
        nm_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dm_next = den[DW-1] ? DW'(-den) : DW'(den);
    end

    always_comb
    begin
        hi_part = nm_reg[NUM_W-1:QB];
        ovf_next = (hi_part >= HW'(dm1_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg    <= neg1_next;
            zero1_reg   <= zero1_next;
            nm_reg      <= nm_next;
            dm1_reg     <= dm_next;
            rem_reg[0]  <= hi_part[DW-1:0];
            lo_reg[0]   <= nm_reg[QB-1:0];
            qt_reg[0]   <= '0;
            dm_reg[0]   <= dm1_reg;
            neg_reg[0]  <= neg1_reg;
            zero_reg[0] <= zero1_reg;
            ovf_reg[0]  <= ovf_next;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            trial = {rem_reg[k-1], lo_reg[k-1][QB-1]};
            ge = (trial >= {1'b0, dm_reg[k-1]});
            rem_next = ge ? DW'(trial - {1'b0, dm_reg[k-1]}) : trial[DW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                lo_reg[k]   <= lo_reg[k-1] << 1;
                qt_reg[k]   <= {qt_reg[k-1][QB-2:0], ge};
                dm_reg[k]   <= dm_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[QB])
            q_next = '0;
        else if (ovf_reg[QB])
            q_next = neg_reg[QB] ? Q_MIN : Q_MAX;
        else if (neg_reg[QB])
            q_next = ~{1'b0, qt_reg[QB]} + DW'(1);
        else
            q_next = {1'b0, qt_reg[QB]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign quo = $signed(q_reg);

endmodule

// ----- rtl/core/closest_points_between_lines.sv -----
`timescale 1ns / 1ps
// Closest points between two 3D lines in signed fixed point, fully pipelined.
// Uses cpl_pkg, cpl_mul and cpl_div.
//
//  channel  dir  handshake          payload
//  s_       in   tvalid / tready    tdata: both lines' start and end points
//  m_       out  tvalid / tready    tdata: both near points, tuser: parallel flag
//  cfg_     in   wen                wdata: parallel limit on D
//
// One word is accepted per cycle while the skid register is empty; the
// divider forms one quotient bit per stage over WIDE_BITS - 1 stages.
// Reset clears all valid bits and sets the parallel limit to 7.
// A stalled output fills a one-word skid register, after which the whole
// pipeline holds until the output drains.
module closest_points_between_lines #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
    // a_end_z, b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z.
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0: near_a_x, near_a_y, near_a_z, near_b_x, near_b_y,
    // near_b_z.
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
    // Fields from bit 0: lines_parallel.
    output logic                                  m_tuser,
    input  logic                                  cfg_wen,
    input  logic [cpl_pkg::LIMIT_BITS-1:0]        cfg_wdata
);

    localparam int CW = COORD_WIDTH;
    localparam int UW = CW + 1;
    localparam int WB = cpl_pkg::WIDE_BITS;
    localparam int DOT_W = 2 * UW + 2;
    localparam int DOT_EXT = (DOT_W > WB + 1) ? DOT_W : WB + 1;
    localparam int PROD_W = 2 * WB;
    localparam int NUM_W = PROD_W + 1;
    localparam int OUT_W = ((6 * CW + 7) / 8) * 8;
    localparam int MUL_LAT = 3;
    localparam int DIV_LAT = WB + 2;

    localparam int S_UVW = 1;
    localparam int S_PROD = 2;
    localparam int S_DOT = 3;
    localparam int S_MUL1 = S_DOT + MUL_LAT;
    localparam int S_DIFF = S_MUL1 + 1;
    localparam int S_SEL = S_DIFF + 1;
    localparam int S_DIV = S_SEL + DIV_LAT;
    localparam int S_MUL2 = S_DIV + MUL_LAT;
    localparam int S_LAST = S_MUL2 + 1;

    localparam int DOT_A = 0;
    localparam int DOT_B = 1;
    localparam int DOT_C = 2;
    localparam int DOT_D = 3;
    localparam int DOT_E = 4;

    localparam logic [WB-1:0] WB_MAX = {1'b0, {(WB-1){1'b1}}};
    localparam logic [WB-1:0] WB_MIN = {1'b1, {(WB-1){1'b0}}};
    localparam logic [CW-1:0] CW_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CW_MIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [WB-1:0] sat_dot(input logic signed [DOT_EXT-1:0] x);
        logic [DOT_EXT-WB:0] top;
        top = x[DOT_EXT-1:WB-1];
        if ((&top) || !(|top))
            return $signed(x[WB-1:0]);
        return x[DOT_EXT-1] ? $signed(WB_MIN) : $signed(WB_MAX);
    endfunction

    function automatic logic signed [WB-1:0] sat_num(input logic signed [NUM_W-1:0] x);
        logic [NUM_W-WB:0] top;
        top = x[NUM_W-1:WB-1];
        if ((&top) || !(|top))
            return $signed(x[WB-1:0]);
        return x[NUM_W-1] ? $signed(WB_MIN) : $signed(WB_MAX);
    endfunction

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [NUM_W-1:0] x);
        logic [NUM_W-CW:0] top;
        top = x[NUM_W-1:CW-1];
        if ((&top) || !(|top))
            return $signed(x[CW-1:0]);
        return x[NUM_W-1] ? $signed(CW_MIN) : $signed(CW_MAX);
    endfunction

    logic en;
    logic arrive;
    logic [S_LAST:1] v_reg;
    logic [cpl_pkg::LIMIT_BITS-1:0] limit_reg;

    // Stage 1: direction and offset vectors.
    logic signed [CW-1:0] as_next [0:2];
    logic signed [CW-1:0] ae_next [0:2];
    logic signed [CW-1:0] bs_next [0:2];
    logic signed [CW-1:0] be_next [0:2];
    logic signed [UW-1:0] u_next  [0:2];
    logic signed [UW-1:0] v_next  [0:2];
    logic signed [UW-1:0] w_next  [0:2];
    logic signed [UW-1:0] w_reg   [0:2];

    logic signed [CW-1:0] as_pipe_reg [S_UVW:S_MUL2][0:2];
    logic signed [CW-1:0] bs_pipe_reg [S_UVW:S_MUL2][0:2];
    logic signed [UW-1:0] u_pipe_reg  [S_UVW:S_DIV][0:2];
    logic signed [UW-1:0] v_pipe_reg  [S_UVW:S_DIV][0:2];

    // Stage 2: products for the five dot products.
    logic signed [2*UW-1:0] prod_next [0:4][0:2];
    logic signed [2*UW-1:0] prod_reg  [0:4][0:2];

    // Stage 3: rescaled dot products.
    logic signed [DOT_W-1:0] dsum [0:4];
    logic signed [WB-1:0]    dot_next [0:4];
    logic signed [WB-1:0]    dot_pipe_reg [S_DOT:S_MUL1][0:4];

    logic signed [WB-1:0]     m1_x [0:5];
    logic signed [WB-1:0]     m1_y [0:5];
    logic signed [PROD_W-1:0] m1_p [0:5];

    // Stage after the first products: D and the two numerators.
    logic signed [NUM_W-1:0] dd_full;
    logic signed [WB-1:0]    dd_next, dd_reg;
    logic signed [NUM_W-1:0] sn_next, tn_next, sn_reg, tn_reg;
    logic                    b_gt_c;
    logic signed [WB-1:0]    pd_next, pden_next, pd_reg, pden_reg;

    // Selection stage.
    logic                    par_next;
    logic signed [NUM_W-1:0] num_s_next, num_t_next, num_s_reg, num_t_reg;
    logic signed [WB-1:0]    den_s_next, den_t_next, den_s_reg, den_t_reg;
    logic                    par_pipe_reg [S_SEL:S_LAST];

    logic signed [WB-1:0] sc, tc;

    logic signed [WB-1:0]     m2_x [0:5];
    logic signed [WB-1:0]     m2_y [0:5];
    logic signed [PROD_W-1:0] m2_p [0:5];

    logic signed [NUM_W-1:0] near_sum [0:5];
    logic signed [CW-1:0]    near_next [0:5];
    logic signed [CW-1:0]    near_reg  [0:5];
    logic [OUT_W-1:0]        pack_word;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next, skid_data_reg, skid_data_next;
    logic             out_par_reg, out_par_next, skid_par_reg, skid_par_next;

    assign en = !skid_valid_reg;
    assign s_tready = en;
    assign arrive = en && v_reg[S_LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= cpl_pkg::LIMIT_RESET;
        else if (cfg_wen)
            limit_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[S_LAST-1:1], s_tvalid};
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            as_next[i] = $signed(s_tdata[i*CW +: CW]);
            ae_next[i] = $signed(s_tdata[(3+i)*CW +: CW]);
            bs_next[i] = $signed(s_tdata[(6+i)*CW +: CW]);
            be_next[i] = $signed(s_tdata[(9+i)*CW +: CW]);
            u_next[i] = UW'(ae_next[i]) - UW'(as_next[i]);
            v_next[i] = UW'(be_next[i]) - UW'(bs_next[i]);
            w_next[i] = UW'(as_next[i]) - UW'(bs_next[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[DOT_A][i] = u_pipe_reg[S_UVW][i] * u_pipe_reg[S_UVW][i];
            prod_next[DOT_B][i] = u_pipe_reg[S_UVW][i] * v_pipe_reg[S_UVW][i];
            prod_next[DOT_C][i] = v_pipe_reg[S_UVW][i] * v_pipe_reg[S_UVW][i];
            prod_next[DOT_D][i] = u_pipe_reg[S_UVW][i] * w_reg[i];
            prod_next[DOT_E][i] = v_pipe_reg[S_UVW][i] * w_reg[i];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            dsum[j] = DOT_W'(prod_reg[j][0]) + DOT_W'(prod_reg[j][1])
                    + DOT_W'(prod_reg[j][2]);
            dot_next[j] = sat_dot(DOT_EXT'(dsum[j] >>> FRAC_BITS));
        end
    end

    always_comb
    begin
        m1_x[0] = dot_pipe_reg[S_DOT][DOT_A];
        m1_y[0] = dot_pipe_reg[S_DOT][DOT_C];
        m1_x[1] = dot_pipe_reg[S_DOT][DOT_B];
        m1_y[1] = dot_pipe_reg[S_DOT][DOT_B];
        m1_x[2] = dot_pipe_reg[S_DOT][DOT_B];
        m1_y[2] = dot_pipe_reg[S_DOT][DOT_E];
        m1_x[3] = dot_pipe_reg[S_DOT][DOT_C];
        m1_y[3] = dot_pipe_reg[S_DOT][DOT_D];
        m1_x[4] = dot_pipe_reg[S_DOT][DOT_A];
        m1_y[4] = dot_pipe_reg[S_DOT][DOT_E];
        m1_x[5] = dot_pipe_reg[S_DOT][DOT_B];
        m1_y[5] = dot_pipe_reg[S_DOT][DOT_D];
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_mul1
        cpl_mul #(
            .W (WB)
        ) u_mul (
            .clk (clk),
            .en  (en),
            .x   (m1_x[g]),
            .y   (m1_y[g]),
            .p   (m1_p[g])
        );
    end

    always_comb
    begin
        dd_full = NUM_W'(m1_p[0]) - NUM_W'(m1_p[1]);
        dd_next = sat_num(dd_full >>> FRAC_BITS);
        sn_next = NUM_W'(m1_p[2]) - NUM_W'(m1_p[3]);
        tn_next = NUM_W'(m1_p[4]) - NUM_W'(m1_p[5]);
        b_gt_c = dot_pipe_reg[S_MUL1][DOT_B] > dot_pipe_reg[S_MUL1][DOT_C];
        pd_next = b_gt_c ? dot_pipe_reg[S_MUL1][DOT_D] : dot_pipe_reg[S_MUL1][DOT_E];
        pden_next = b_gt_c ? dot_pipe_reg[S_MUL1][DOT_B] : dot_pipe_reg[S_MUL1][DOT_C];
    end

    always_comb
    begin
        par_next = dd_reg < $signed({{(WB-cpl_pkg::LIMIT_BITS){1'b0}}, limit_reg});
        num_s_next = par_next ? '0 : sn_reg;
        den_s_next = dd_reg;
        num_t_next = par_next ? (NUM_W'(pd_reg) <<< FRAC_BITS) : tn_reg;
        den_t_next = par_next ? pden_reg : dd_reg;
    end

    cpl_div #(
        .NUM_W (NUM_W)
    ) u_div_s (
        .clk (clk),
        .en  (en),
        .num (num_s_reg),
        .den (den_s_reg),
        .quo (sc)
    );

    cpl_div #(
        .NUM_W (NUM_W)
    ) u_div_t (
        .clk (clk),
        .en  (en),
        .num (num_t_reg),
        .den (den_t_reg),
        .quo (tc)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m2_x[i] = sc;
            m2_y[i] = WB'(u_pipe_reg[S_DIV][i]);
            m2_x[3+i] = tc;
            m2_y[3+i] = WB'(v_pipe_reg[S_DIV][i]);
        end
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_mul2
        cpl_mul #(
            .W (WB)
        ) u_mul (
            .clk (clk),
            .en  (en),
            .x   (m2_x[g]),
            .y   (m2_y[g]),
            .p   (m2_p[g])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            near_sum[i] = NUM_W'(as_pipe_reg[S_MUL2][i])
                        + (NUM_W'(m2_p[i]) >>> FRAC_BITS);
            near_sum[3+i] = NUM_W'(bs_pipe_reg[S_MUL2][i])
                          + (NUM_W'(m2_p[3+i]) >>> FRAC_BITS);
        end
        for (int j = 0; j < 6; j++)
        begin
            near_next[j] = sat_coord(near_sum[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                as_pipe_reg[S_UVW][i] <= as_next[i];
                bs_pipe_reg[S_UVW][i] <= bs_next[i];
                u_pipe_reg[S_UVW][i] <= u_next[i];
                v_pipe_reg[S_UVW][i] <= v_next[i];
                w_reg[i] <= w_next[i];
                for (int k = S_UVW + 1; k <= S_MUL2; k++)
                begin
                    as_pipe_reg[k][i] <= as_pipe_reg[k-1][i];
                    bs_pipe_reg[k][i] <= bs_pipe_reg[k-1][i];
                end
                for (int k = S_UVW + 1; k <= S_DIV; k++)
                begin
                    u_pipe_reg[k][i] <= u_pipe_reg[k-1][i];
                    v_pipe_reg[k][i] <= v_pipe_reg[k-1][i];
                end
            end
            prod_reg <= prod_next;
            for (int j = 0; j < 5; j++)
            begin
                dot_pipe_reg[S_DOT][j] <= dot_next[j];
                for (int k = S_DOT + 1; k <= S_MUL1; k++)
                begin
                    dot_pipe_reg[k][j] <= dot_pipe_reg[k-1][j];
                end
            end
            dd_reg <= dd_next;
            sn_reg <= sn_next;
            tn_reg <= tn_next;
            pd_reg <= pd_next;
            pden_reg <= pden_next;
            num_s_reg <= num_s_next;
            num_t_reg <= num_t_next;
            den_s_reg <= den_s_next;
            den_t_reg <= den_t_next;
            par_pipe_reg[S_SEL] <= par_next;
            for (int k = S_SEL + 1; k <= S_LAST; k++)
            begin
                par_pipe_reg[k] <= par_pipe_reg[k-1];
            end
            near_reg <= near_next;
        end
    end

    assign pack_word = OUT_W'({near_reg[5], near_reg[4], near_reg[3],
                               near_reg[2], near_reg[1], near_reg[0]});

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next = out_data_reg;
        out_par_next = out_par_reg;
        skid_data_next = skid_data_reg;
        skid_par_next = skid_par_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next = skid_data_reg;
                out_par_next = skid_par_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = arrive;
                out_data_next = pack_word;
                out_par_next = par_pipe_reg[S_LAST];
            end
        end
        else if (arrive)
        begin
            skid_valid_next = 1'b1;
            skid_data_next = pack_word;
            skid_par_next = par_pipe_reg[S_LAST];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_par_reg <= out_par_next;
        skid_data_reg <= skid_data_next;
        skid_par_reg <= skid_par_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_par_reg;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid register filled without an output stall");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> $stable(v_reg))
        else $error("pipeline advanced while the skid register was full");
`endif

endmodule
